>>> hdl/tepq_pkg.sv
// ----------------------------------------------------------------------------
// tepq_pkg: shared definitions for the timed event priority queue
// Result codes, kind limit, default sizes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package tepq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_MAX = 3'd4;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_KIND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // broadcast to every cell
  typedef struct packed {
    logic ins_en;   // place new event in the row this cycle
    logic pop_en;   // shift row towards the head this cycle
  } cell_ctrl_t;

endpackage

>>> hdl/timed_event_priority_queue.sv
// ----------------------------------------------------------------------------
// timed_event_priority_queue: bounded sorted-list event queue
// Result: strobe out_valid is registered from the start transfer and rises in the cycle after it.
// Throughput: one request per cycle; busy is held low, every cell decides
// its next contents in parallel from its own compare and its neighbours.
// Reset (rst_n, synchronous): row emptied, count zero, no result pending.
// The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module timed_event_priority_queue #(
  parameter int DEPTH     = tepq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = tepq_pkg::TIME_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [TIME_BITS-1:0]          in_event_time,
  input  logic [tepq_pkg::KIND_W-1:0]   in_event_kind,
  // result channel
  output logic                          out_valid,
  output logic [tepq_pkg::STATUS_W-1:0] out_status,
  output logic [TIME_BITS-1:0]          out_time,
  output logic [tepq_pkg::KIND_W-1:0]   out_kind,
  output logic [CNT_W-1:0]              out_occupancy
);
  import tepq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // ---- request decode ------------------------------------------------------
  // Every request is taken at once; the row is updated in the same edge.
  logic accept;
  logic is_pop;
  logic kind_bad;
  logic full;
  logic empty;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_pop   = (in_req_type == REQ_POP);
  assign kind_bad = (in_event_kind > KIND_MAX);

  logic [CNT_W-1:0] count_r, count_nxt;
  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);

  cell_ctrl_t ctrl;
  logic [STATUS_W-1:0] status_c;

  // Bad kind is checked before fullness; a dropped insert leaves the row.
  always_comb begin
    ctrl      = '0;
    status_c  = ST_OK;
    count_nxt = count_r;
    if (accept) begin
      if (is_pop) begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          ctrl.pop_en = 1'b1;
          count_nxt   = count_r - 1'b1;
        end
      end else begin
        if (kind_bad) begin
          status_c = ST_BAD_KIND;
        end else if (full) begin
          status_c = ST_FULL;
        end else begin
          ctrl.ins_en = 1'b1;
          count_nxt   = count_r + 1'b1;
        end
      end
    end
  end

  // ---- row of cells --------------------------------------------------------
  // Cell 0 is the head (earliest). On insert the first cell whose event is
  // later than the new one (or empty) takes it; cells behind take their left
  // neighbour. On pop every cell takes its right neighbour.
  logic [DEPTH-1:0]     cell_valid;
  logic [DEPTH-1:0]     cell_ahead;
  logic [TIME_BITS-1:0] cell_time [DEPTH];
  logic [KIND_W-1:0]    cell_kind [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 l_valid, l_ahead, r_valid;
    logic [TIME_BITS-1:0] l_time, r_time;
    logic [KIND_W-1:0]    l_kind, r_kind;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_ahead = 1'b0;
      assign l_time  = '0;
      assign l_kind  = '0;
    end else begin : g_mid
      assign l_valid = cell_valid[i-1];
      assign l_ahead = cell_ahead[i-1];
      assign l_time  = cell_time[i-1];
      assign l_kind  = cell_kind[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_time  = '0;
      assign r_kind  = '0;
    end else begin : g_body
      assign r_valid = cell_valid[i+1];
      assign r_time  = cell_time[i+1];
      assign r_kind  = cell_kind[i+1];
    end

    tepq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_time    (in_event_time),
      .new_kind    (in_event_kind),
      .left_valid  (l_valid),
      .left_time   (l_time),
      .left_kind   (l_kind),
      .left_ahead  (l_ahead),
      .right_valid (r_valid),
      .right_time  (r_time),
      .right_kind  (r_kind),
      .valid       (cell_valid[i]),
      .time_q      (cell_time[i]),
      .kind_q      (cell_kind[i]),
      .ahead       (cell_ahead[i])
    );
  end

  // ---- result register -----------------------------------------------------
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [CNT_W-1:0]     occ_r;

  // popped event comes off the head; zero for everything else
  assign time_nxt = ctrl.pop_en ? cell_time[0] : '0;
  assign kind_nxt = ctrl.pop_en ? cell_kind[0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_c;
      time_r   <= time_nxt;
      kind_r   <= kind_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_time      = time_r;
  assign out_kind      = kind_r;
  assign out_occupancy = occ_r;

  // ---- checks --------------------------------------------------------------
  // held events always fill the row from the head, matching the count
  a_row_packed : assert property (@(posedge clk) disable iff (!rst_n)
    (((cell_valid + 1'b1) & cell_valid) == '0) &&
    ($countones(cell_valid) == int'(count_r)))
    else $error("cell row not packed from head or count mismatch");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("event count above depth");

  a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request gave no result");

  a_empty_pop : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EMPTY)) |->
    ((out_occupancy == '0) && (out_time == '0) && (out_kind == '0)))
    else $error("empty pop reported data or occupancy");

endmodule

>>> hdl/tepq_cell.sv
// ----------------------------------------------------------------------------
// tepq_cell: one slot of the sorted event row
// Holds one event; on insert keeps, takes the new event or takes the left
// neighbour's; on pop takes the right neighbour's.
// ----------------------------------------------------------------------------
module tepq_cell #(
  parameter int TIME_BITS = tepq_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tepq_pkg::cell_ctrl_t       ctrl,
  input  logic [TIME_BITS-1:0]       new_time,
  input  logic [tepq_pkg::KIND_W-1:0] new_kind,
  input  logic                       left_valid,
  input  logic [TIME_BITS-1:0]       left_time,
  input  logic [tepq_pkg::KIND_W-1:0] left_kind,
  input  logic                       left_ahead,
  input  logic                       right_valid,
  input  logic [TIME_BITS-1:0]       right_time,
  input  logic [tepq_pkg::KIND_W-1:0] right_kind,
  output logic                       valid,
  output logic [TIME_BITS-1:0]       time_q,
  output logic [tepq_pkg::KIND_W-1:0] kind_q,
  output logic                       ahead
);
  import tepq_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;

  // new event belongs at or ahead of this slot (ties stay behind)
  assign ahead = !valid_r || (time_r > new_time);

  always_comb begin
    valid_nxt = valid_r;
    time_nxt  = time_r;
    kind_nxt  = kind_r;
    if (ctrl.ins_en && ahead) begin
      if (left_ahead) begin
        valid_nxt = left_valid;
        time_nxt  = left_time;
        kind_nxt  = left_kind;
      end else begin
        valid_nxt = 1'b1;
        time_nxt  = new_time;
        kind_nxt  = new_kind;
      end
    end else if (ctrl.pop_en) begin
      valid_nxt = right_valid;
      time_nxt  = right_time;
      kind_nxt  = right_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r <= time_nxt;
    kind_r <= kind_nxt;
  end

  assign valid  = valid_r;
  assign time_q = time_r;
  assign kind_q = kind_r;

endmodule
